/* hdl/dsc_pkg.sv */
// Shared types and constants for the depth-to-spectrum color pipeline.
package dsc_pkg;

    localparam int TOLERANCE    = 5;
    localparam int Q_BITS       = 19;
    localparam int W_BITS       = 20;
    localparam int FRAC_BITS    = 17;
    localparam int RAMP_BITS    = 17;
    localparam int RAMP_X_BITS  = 23;
    localparam int FADE_X_BITS  = 22;
    localparam int RECIP_BITS   = 28;
    localparam int K_BITS       = 7;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DEPTH_LOW  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEPTH_HIGH = CFG_IDX_BITS'(1);

    // Wavelength breakpoints in units of 1/1024 nm.
    localparam logic [W_BITS-1:0] NM_350 = W_BITS'(350 * 1024);
    localparam logic [W_BITS-1:0] NM_420 = W_BITS'(420 * 1024);
    localparam logic [W_BITS-1:0] NM_440 = W_BITS'(440 * 1024);
    localparam logic [W_BITS-1:0] NM_490 = W_BITS'(490 * 1024);
    localparam logic [W_BITS-1:0] NM_510 = W_BITS'(510 * 1024);
    localparam logic [W_BITS-1:0] NM_580 = W_BITS'(580 * 1024);
    localparam logic [W_BITS-1:0] NM_645 = W_BITS'(645 * 1024);
    localparam logic [W_BITS-1:0] NM_680 = W_BITS'(680 * 1024);
    localparam logic [W_BITS-1:0] NM_750 = W_BITS'(750 * 1024);

    localparam logic [FRAC_BITS-1:0] FRAC_ONE  = FRAC_BITS'(65536);
    localparam logic [FRAC_BITS-1:0] FADE_BASE = FRAC_BITS'(19661);
    localparam logic [RAMP_BITS-1:0] FADE_SPAN = RAMP_BITS'(45875);

    // Ramp span in nm; a ramp is floor(num * 64 / span).
    localparam logic [K_BITS-1:0] K_90 = K_BITS'(90);
    localparam logic [K_BITS-1:0] K_50 = K_BITS'(50);
    localparam logic [K_BITS-1:0] K_20 = K_BITS'(20);
    localparam logic [K_BITS-1:0] K_70 = K_BITS'(70);
    localparam logic [K_BITS-1:0] K_65 = K_BITS'(65);

    // floor(2^32 / span): the estimate is low by at most one.
    localparam logic [RECIP_BITS-1:0] RECIP_90 = RECIP_BITS'((64'd1 << 32) / 64'd90);
    localparam logic [RECIP_BITS-1:0] RECIP_50 = RECIP_BITS'((64'd1 << 32) / 64'd50);
    localparam logic [RECIP_BITS-1:0] RECIP_20 = RECIP_BITS'((64'd1 << 32) / 64'd20);
    localparam logic [RECIP_BITS-1:0] RECIP_70 = RECIP_BITS'((64'd1 << 32) / 64'd70);
    localparam logic [RECIP_BITS-1:0] RECIP_65 = RECIP_BITS'((64'd1 << 32) / 64'd65);

    typedef enum logic [2:0] {
        SEG_VIOLET,
        SEG_BLUE,
        SEG_CYAN,
        SEG_GREEN,
        SEG_YELLOW,
        SEG_RED
    } t_seg;

    typedef struct packed {
        logic frame_end;
        logic in_band;
    } t_pix_ctl;

    typedef struct packed {
        t_seg     seg;
        t_pix_ctl ctl;
    } t_ramp_side;

endpackage

/* hdl/dsc_div.sv */
// Pipelined restoring divider: one quotient bit per register stage.
module dsc_div #(
    parameter int DEPTH_BITS = 11
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_v,
    input  logic [DEPTH_BITS+dsc_pkg::Q_BITS-1:0]  i_num,
    input  logic [DEPTH_BITS-1:0]                  i_den,
    input  dsc_pkg::t_pix_ctl                      i_ctl,
    output logic                                   o_v,
    output logic [dsc_pkg::Q_BITS-1:0]             o_q,
    output dsc_pkg::t_pix_ctl                      o_ctl
);
    import dsc_pkg::*;

    localparam int NW = DEPTH_BITS + Q_BITS;

    logic [NW-1:0]         w_rem [Q_BITS];
    logic [Q_BITS-1:0]     w_q   [Q_BITS+1];
    logic [DEPTH_BITS-1:0] w_den [Q_BITS+1];
    t_pix_ctl              w_ctl [Q_BITS+1];
    logic                  w_v   [Q_BITS+1];

    assign w_rem[0] = i_num;
    assign w_q[0]   = '0;
    assign w_den[0] = i_den;
    assign w_ctl[0] = i_ctl;
    assign w_v[0]   = i_v;

    // The quotient is known to fit Q_BITS bits, so stage s tries bit Q_BITS-1-s.
    for (genvar s = 0; s < Q_BITS; s++) begin : g_stage
        localparam int B = Q_BITS - 1 - s;

        logic [NW-1:0]         n_shifted;
        logic                  n_ge;
        logic [Q_BITS-1:0]     r_q;
        logic [DEPTH_BITS-1:0] r_den;
        t_pix_ctl              r_ctl;
        logic                  r_v;

        assign n_shifted = NW'(w_den[s]) << B;
        assign n_ge      = w_rem[s] >= n_shifted;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= w_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_q   <= w_q[s] | (Q_BITS'(n_ge) << B);
            r_den <= w_den[s];
            r_ctl <= w_ctl[s];
        end

        if (s < Q_BITS - 1) begin : g_rem
            logic [NW-1:0] r_rem;

            always_ff @(posedge i_clk) begin
                r_rem <= n_ge ? (w_rem[s] - n_shifted) : w_rem[s];
            end

            assign w_rem[s+1] = r_rem;
        end

        assign w_q[s+1]   = r_q;
        assign w_den[s+1] = r_den;
        assign w_ctl[s+1] = r_ctl;
        assign w_v[s+1]   = r_v;
    end

    assign o_v   = w_v[Q_BITS];
    assign o_q   = w_q[Q_BITS];
    assign o_ctl = w_ctl[Q_BITS];

endmodule

/* hdl/dsc_cdiv.sv */
// Division by a small constant through a reciprocal multiply and one correction step.
module dsc_cdiv #(
    parameter int X_BITS    = 23,
    parameter int SIDE_BITS = 1
) (
    input  logic                             i_clk,
    input  logic [X_BITS-1:0]                i_x,
    input  logic [dsc_pkg::K_BITS-1:0]       i_k,
    input  logic [dsc_pkg::RECIP_BITS-1:0]   i_m,
    input  logic [SIDE_BITS-1:0]             i_side,
    output logic [dsc_pkg::RAMP_BITS-1:0]    o_q,
    output logic [SIDE_BITS-1:0]             o_side
);
    import dsc_pkg::*;

    localparam int PW = X_BITS + RECIP_BITS;

    logic [PW-1:0]        r_prod;
    logic [X_BITS-1:0]    r_xa;
    logic [K_BITS-1:0]    r_ka;
    logic [SIDE_BITS-1:0] r_sa;

    logic [RAMP_BITS-1:0] n_q0;
    logic [X_BITS-1:0]    r_qk;
    logic [RAMP_BITS-1:0] r_qb;
    logic [X_BITS-1:0]    r_xb;
    logic [K_BITS-1:0]    r_kb;
    logic [SIDE_BITS-1:0] r_sb;

    logic [X_BITS-1:0]    n_rem;
    logic [RAMP_BITS-1:0] r_q;
    logic [SIDE_BITS-1:0] r_sc;

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_x) * PW'(i_m);
        r_xa   <= i_x;
        r_ka   <= i_k;
        r_sa   <= i_side;
    end

    assign n_q0 = r_prod[32 +: RAMP_BITS];

    always_ff @(posedge i_clk) begin
        r_qk <= X_BITS'(n_q0) * X_BITS'(r_ka);
        r_qb <= n_q0;
        r_xb <= r_xa;
        r_kb <= r_ka;
        r_sb <= r_sa;
    end

    // The estimate is never high, so the remainder is non-negative and below twice k.
    assign n_rem = r_xb - r_qk;

    always_ff @(posedge i_clk) begin
        r_q  <= (n_rem >= X_BITS'(r_kb)) ? (r_qb + RAMP_BITS'(1)) : r_qb;
        r_sc <= r_sb;
    end

    assign o_q    = r_q;
    assign o_side = r_sc;

endmodule

/* hdl/depth_to_spectrum_color.sv */
// An accepted item passes stages 1 and 2, the divider, stages 3 and 4, the constant dividers and stages 5 to 7.
// Throughput: one item per clock; busy stays low since the pipeline never stalls.
// Depth is set by the 19-stage quotient divider for the wavelength plus the color stages.
// Results appear for one cycle under o_valid; the receiver cannot hold them off.
// Synchronous active-low reset clears all valid bits and loads the bounds 909 and 930.
module depth_to_spectrum_color #(
    parameter int DEPTH_BITS = 11
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_cfg_we,
    input  logic [dsc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [DEPTH_BITS-1:0]              i_cfg_data,
    input  logic [DEPTH_BITS-1:0]              i_depth_sample,
    input  logic                               i_frame_end_in,
    output logic                               o_valid,
    output logic [7:0]                         o_blue_level,
    output logic [7:0]                         o_green_level,
    output logic [7:0]                         o_red_level,
    output logic                               o_frame_end_out
);
    import dsc_pkg::*;

    localparam int NUM_BITS = DEPTH_BITS + 9;

    logic [DEPTH_BITS-1:0] r_depth_low;
    logic [DEPTH_BITS-1:0] r_depth_high;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_low  <= DEPTH_BITS'(909);
            r_depth_high <= DEPTH_BITS'(930);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEPTH_LOW:  r_depth_low  <= i_cfg_data;
                CFG_DEPTH_HIGH: r_depth_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: band test against the bounds lowered by the tolerance.
    logic [DEPTH_BITS:0]   n_d5;
    logic                  n_in_band;
    logic                  r1_v;
    logic [DEPTH_BITS-1:0] r1_diff;
    logic [DEPTH_BITS-1:0] r1_den;
    t_pix_ctl              r1_ctl;

    assign n_d5      = {1'b0, i_depth_sample} + (DEPTH_BITS+1)'(TOLERANCE);
    assign n_in_band = (r_depth_high > r_depth_low)
                    && (n_d5 >= {1'b0, r_depth_low})
                    && (n_d5 <= {1'b0, r_depth_high});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_diff <= DEPTH_BITS'(n_d5 - {1'b0, r_depth_low});
        r1_den  <= r_depth_high - r_depth_low;
        r1_ctl  <= '{frame_end: i_frame_end_in, in_band: n_in_band};
    end

    // Stage 2: numerator (d - lo) * 400; the factor 1024 is appended as zeros.
    logic                  r2_v;
    logic [NUM_BITS-1:0]   r2_num;
    logic [DEPTH_BITS-1:0] r2_den;
    t_pix_ctl              r2_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_num <= NUM_BITS'(r1_diff) * NUM_BITS'(400);
        r2_den <= r1_den;
        r2_ctl <= r1_ctl;
    end

    logic              div_v;
    logic [Q_BITS-1:0] div_q;
    t_pix_ctl          div_ctl;

    dsc_div #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (r2_v),
        .i_num   ({r2_num, 10'b0}),
        .i_den   (r2_den),
        .i_ctl   (r2_ctl),
        .o_v     (div_v),
        .o_q     (div_q),
        .o_ctl   (div_ctl)
    );

    // Stage 3: wavelength, spectral segment, ramp operands and fade distance.
    logic [W_BITS-1:0]     n_w;
    t_seg                  n_seg;
    logic [W_BITS-1:0]     n_num_w;
    logic [K_BITS-1:0]     n_k;
    logic [RECIP_BITS-1:0] n_m;
    logic                  n_fon;
    logic [W_BITS-1:0]     n_t_w;

    assign n_w = NM_350 + W_BITS'(div_q);

    always_comb begin
        if (n_w < NM_440) begin
            n_seg = SEG_VIOLET;
        end else if (n_w < NM_490) begin
            n_seg = SEG_BLUE;
        end else if (n_w < NM_510) begin
            n_seg = SEG_CYAN;
        end else if (n_w < NM_580) begin
            n_seg = SEG_GREEN;
        end else if (n_w < NM_645) begin
            n_seg = SEG_YELLOW;
        end else begin
            n_seg = SEG_RED;
        end
    end

    always_comb begin
        case (n_seg)
            SEG_VIOLET: begin
                n_num_w = NM_440 - n_w;
                n_k     = K_90;
                n_m     = RECIP_90;
            end
            SEG_BLUE: begin
                n_num_w = n_w - NM_440;
                n_k     = K_50;
                n_m     = RECIP_50;
            end
            SEG_CYAN: begin
                n_num_w = NM_510 - n_w;
                n_k     = K_20;
                n_m     = RECIP_20;
            end
            SEG_GREEN: begin
                n_num_w = n_w - NM_510;
                n_k     = K_70;
                n_m     = RECIP_70;
            end
            SEG_YELLOW: begin
                n_num_w = NM_645 - n_w;
                n_k     = K_65;
                n_m     = RECIP_65;
            end
            default: begin
                n_num_w = '0;
                n_k     = K_65;
                n_m     = RECIP_65;
            end
        endcase
    end

    assign n_fon = (n_w < NM_420) || (n_w >= NM_680);
    assign n_t_w = (n_w < NM_420) ? (n_w - NM_350) : (NM_750 - n_w);

    logic                   r3_v;
    logic [RAMP_X_BITS-1:0] r3_x;
    logic [K_BITS-1:0]      r3_k;
    logic [RECIP_BITS-1:0]  r3_m;
    t_ramp_side             r3_side;
    logic                   r3_fon;
    logic [FRAC_BITS-1:0]   r3_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_x    <= {n_num_w[FRAC_BITS-1:0], 6'b0};
        r3_k    <= n_k;
        r3_m    <= n_m;
        r3_side <= '{seg: n_seg, ctl: div_ctl};
        r3_fon  <= n_fon;
        r3_t    <= n_t_w[FRAC_BITS-1:0];
    end

    // Stage 4: fade numerator scaled down by 1024; the ramp operands are held in the stage 4 registers.
    logic [32:0]            n_fprod;
    logic                   r4_v;
    logic [RAMP_X_BITS-1:0] r4_x;
    logic [K_BITS-1:0]      r4_k;
    logic [RECIP_BITS-1:0]  r4_m;
    t_ramp_side             r4_side;
    logic                   r4_fon;
    logic [FADE_X_BITS-1:0] r4_fx;

    assign n_fprod = 33'(FADE_SPAN) * 33'(r3_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_x    <= r3_x;
        r4_k    <= r3_k;
        r4_m    <= r3_m;
        r4_side <= r3_side;
        r4_fon  <= r3_fon;
        r4_fx   <= n_fprod[10 +: FADE_X_BITS];
    end

    logic [RAMP_BITS-1:0] ramp_q;
    t_ramp_side           ramp_side;
    logic [RAMP_BITS-1:0] fade_q;
    logic [0:0]           fade_on;
    logic [2:0]           r_cdv;

    dsc_cdiv #(
        .X_BITS    (RAMP_X_BITS),
        .SIDE_BITS ($bits(t_ramp_side))
    ) u_ramp_div (
        .i_clk  (i_clk),
        .i_x    (r4_x),
        .i_k    (r4_k),
        .i_m    (r4_m),
        .i_side (r4_side),
        .o_q    (ramp_q),
        .o_side (ramp_side)
    );

    dsc_cdiv #(
        .X_BITS    (FADE_X_BITS),
        .SIDE_BITS (1)
    ) u_fade_div (
        .i_clk  (i_clk),
        .i_x    (r4_fx),
        .i_k    (K_70),
        .i_m    (RECIP_70),
        .i_side (r4_fon),
        .o_q    (fade_q),
        .o_side (fade_on)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cdv <= '0;
        end else begin
            r_cdv <= {r_cdv[1:0], r4_v};
        end
    end

    // Stage 5: fade factor and per-channel fractions; black outside the band.
    logic [FRAC_BITS-1:0] n_ramp;
    logic [FRAC_BITS-1:0] n_cr;
    logic [FRAC_BITS-1:0] n_cg;
    logic [FRAC_BITS-1:0] n_cb;
    logic                 r5_v;
    logic [FRAC_BITS-1:0] r5_cr;
    logic [FRAC_BITS-1:0] r5_cg;
    logic [FRAC_BITS-1:0] r5_cb;
    logic [FRAC_BITS-1:0] r5_f;
    logic                 r5_fe;

    assign n_ramp = FRAC_BITS'(ramp_q);

    always_comb begin
        case (ramp_side.seg)
            SEG_VIOLET: begin
                n_cr = n_ramp;
                n_cg = '0;
                n_cb = FRAC_ONE;
            end
            SEG_BLUE: begin
                n_cr = '0;
                n_cg = n_ramp;
                n_cb = FRAC_ONE;
            end
            SEG_CYAN: begin
                n_cr = '0;
                n_cg = FRAC_ONE;
                n_cb = n_ramp;
            end
            SEG_GREEN: begin
                n_cr = n_ramp;
                n_cg = FRAC_ONE;
                n_cb = '0;
            end
            SEG_YELLOW: begin
                n_cr = FRAC_ONE;
                n_cg = n_ramp;
                n_cb = '0;
            end
            default: begin
                n_cr = FRAC_ONE;
                n_cg = '0;
                n_cb = '0;
            end
        endcase
        if (!ramp_side.ctl.in_band) begin
            n_cr = '0;
            n_cg = '0;
            n_cb = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r_cdv[2];
        end
    end

    always_ff @(posedge i_clk) begin
        r5_cr <= n_cr;
        r5_cg <= n_cg;
        r5_cb <= n_cb;
        r5_f  <= fade_on[0] ? (FADE_BASE + FRAC_BITS'(fade_q)) : FRAC_ONE;
        r5_fe <= ramp_side.ctl.frame_end;
    end

    // Stage 6: fraction times fade factor.
    logic [2*FRAC_BITS-1:0] n_pr;
    logic [2*FRAC_BITS-1:0] n_pg;
    logic [2*FRAC_BITS-1:0] n_pb;
    logic                   r6_v;
    logic [FRAC_BITS-1:0]   r6_pr;
    logic [FRAC_BITS-1:0]   r6_pg;
    logic [FRAC_BITS-1:0]   r6_pb;
    logic                   r6_fe;

    assign n_pr = (2*FRAC_BITS)'(r5_cr) * (2*FRAC_BITS)'(r5_f);
    assign n_pg = (2*FRAC_BITS)'(r5_cg) * (2*FRAC_BITS)'(r5_f);
    assign n_pb = (2*FRAC_BITS)'(r5_cb) * (2*FRAC_BITS)'(r5_f);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_pr <= n_pr[16 +: FRAC_BITS];
        r6_pg <= n_pg[16 +: FRAC_BITS];
        r6_pb <= n_pb[16 +: FRAC_BITS];
        r6_fe <= r5_fe;
    end

    // Stage 7: byte = floor(255 * p / 65536), with 255 * p done as a shift and subtract.
    logic [24:0] n_br;
    logic [24:0] n_bg;
    logic [24:0] n_bb;

    assign n_br = (25'(r6_pr) << 8) - 25'(r6_pr);
    assign n_bg = (25'(r6_pg) << 8) - 25'(r6_pg);
    assign n_bb = (25'(r6_pb) << 8) - 25'(r6_pb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        o_red_level     <= n_br[23:16];
        o_green_level   <= n_bg[23:16];
        o_blue_level    <= n_bb[23:16];
        o_frame_end_out <= r6_fe;
    end

endmodule

/* verif/tb_depth_to_spectrum_color.sv */
`timescale 1ns / 1ps
// Self-checking testbench for depth_to_spectrum_color: directed table, then fixed and random band settings.
module tb_depth_to_spectrum_color;
    import dsc_pkg::*;

    localparam int DEPTH_BITS   = 11;
    localparam int DEPTH_MAX    = (1 << DEPTH_BITS) - 1;
    localparam int RESET_LOW    = 909;
    localparam int RESET_HIGH   = 930;
    localparam int FLUSH_CYCLES = 40;
    localparam int N_SEGS       = 6;

    localparam logic [63:0] ONE_Q16 = 64'd65536;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_end;
    } t_pixel;

    typedef struct packed {
        logic [DEPTH_BITS-1:0] depth;
        logic                  frame_end;
        logic                  known;
        logic [7:0]            blue;
        logic [7:0]            green;
        logic [7:0]            red;
    } t_dir_row;

    // The band after reset is [904, 925]; rows marked known carry their expected pixel.
    localparam t_dir_row DIR_ROWS [26] = '{
        '{11'd0,    1'b0, 1'b1, 8'd0,  8'd0, 8'd0},
        '{11'd2047, 1'b1, 1'b1, 8'd0,  8'd0, 8'd0},
        '{11'd903,  1'b0, 1'b1, 8'd0,  8'd0, 8'd0},
        '{11'd926,  1'b0, 1'b1, 8'd0,  8'd0, 8'd0},
        '{11'd904,  1'b0, 1'b1, 8'd76, 8'd0, 8'd76},
        '{11'd925,  1'b1, 1'b1, 8'd0,  8'd0, 8'd76},
        '{11'd905,  1'b0, 1'b0, 8'd0,  8'd0, 8'd0},
        '{11'd906,  1'b0, 1'b0, 8'd0,  8'd0, 8'd0},
        '{11'd907,  1'b1, 1'b0, 8'd0,  8'd0, 8'd0},
        '{11'd908,  1'b0, 1'b0, 8'd0,  8'd0, 8'd0},
        '{11'd909,  1'b0, 1'b0, 8'd0,  8'd0, 8'd0},
        '{11'd910,  1'b0, 1'b0, 8'd0,  8'd0, 8'd0},
        '{11'd911,  1'b0, 1'b0, 8'd0,  8'd0, 8'd0},
        '{11'd912,  1'b1, 1'b0, 8'd0,  8'd0, 8'd0},
        '{11'd913,  1'b0, 1'b0, 8'd0,  8'd0, 8'd0},
        '{11'd914,  1'b0, 1'b0, 8'd0,  8'd0, 8'd0},
        '{11'd915,  1'b0, 1'b0, 8'd0,  8'd0, 8'd0},
        '{11'd916,  1'b0, 1'b0, 8'd0,  8'd0, 8'd0},
        '{11'd917,  1'b0, 1'b0, 8'd0,  8'd0, 8'd0},
        '{11'd918,  1'b1, 1'b0, 8'd0,  8'd0, 8'd0},
        '{11'd919,  1'b0, 1'b0, 8'd0,  8'd0, 8'd0},
        '{11'd920,  1'b0, 1'b0, 8'd0,  8'd0, 8'd0},
        '{11'd921,  1'b0, 1'b0, 8'd0,  8'd0, 8'd0},
        '{11'd922,  1'b0, 1'b0, 8'd0,  8'd0, 8'd0},
        '{11'd923,  1'b0, 1'b0, 8'd0,  8'd0, 8'd0},
        '{11'd924,  1'b1, 1'b0, 8'd0,  8'd0, 8'd0}
    };

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [DEPTH_BITS-1:0]   i_cfg_data;
    logic [DEPTH_BITS-1:0]   i_depth_sample;
    logic                    i_frame_end_in;
    logic                    o_valid;
    logic [7:0]              o_blue_level;
    logic [7:0]              o_green_level;
    logic [7:0]              o_red_level;
    logic                    o_frame_end_out;

    logic [DEPTH_BITS-1:0] band_low;
    logic [DEPTH_BITS-1:0] band_high;
    t_pixel                expected_pixels [$];
    int                    n_sent;
    int                    n_checked;
    int                    n_errors;
    int                    n_in_band;
    int                    n_settings;
    int                    burst_left;
    int                    seg_hits [N_SEGS];

    depth_to_spectrum_color #(
        .DEPTH_BITS(DEPTH_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_depth_sample (i_depth_sample),
        .i_frame_end_in (i_frame_end_in),
        .o_valid        (o_valid),
        .o_blue_level   (o_blue_level),
        .o_green_level  (o_green_level),
        .o_red_level    (o_red_level),
        .o_frame_end_out(o_frame_end_out)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [63:0] ramp_q16(input logic [63:0] num, input logic [63:0] den);
        return (num << 16) / den;
    endfunction

    function automatic logic [7:0] color_byte(input logic [63:0] color, input logic [63:0] fade);
        logic [63:0] p;
        p = (color * fade) >> 16;
        return 8'((64'd255 * p) >> 16);
    endfunction

    // Depth to wavelength, wavelength to color fractions, then fade and byte scaling.
    function automatic void predict_pixel(
        input  logic [DEPTH_BITS-1:0] depth,
        input  logic                  frame_end,
        input  logic [DEPTH_BITS-1:0] low_reg,
        input  logic [DEPTH_BITS-1:0] high_reg,
        output t_pixel                px,
        output logic                  in_band,
        output t_seg                  seg
    );
        longint      lo;
        longint      hi;
        longint      dd;
        logic [63:0] w;
        logic [63:0] r;
        logic [63:0] g;
        logic [63:0] b;
        logic [63:0] f;
        lo = low_reg;
        hi = high_reg;
        dd = depth;
        lo = lo - TOLERANCE;
        hi = hi - TOLERANCE;
        r = '0;
        g = '0;
        b = '0;
        f = '0;
        seg = SEG_VIOLET;
        in_band = (hi > lo) && (dd >= lo) && (dd <= hi);
        if (in_band) begin
            w = 64'(NM_350) + (64'(dd - lo) * 64'(400 * 1024)) / 64'(hi - lo);
            if (w < 64'(NM_440)) begin
                seg = SEG_VIOLET;
                r = ramp_q16(64'(NM_440) - w, 64'(90 * 1024));
                b = ONE_Q16;
            end else if (w < 64'(NM_490)) begin
                seg = SEG_BLUE;
                g = ramp_q16(w - 64'(NM_440), 64'(50 * 1024));
                b = ONE_Q16;
            end else if (w < 64'(NM_510)) begin
                seg = SEG_CYAN;
                g = ONE_Q16;
                b = ramp_q16(64'(NM_510) - w, 64'(20 * 1024));
            end else if (w < 64'(NM_580)) begin
                seg = SEG_GREEN;
                r = ramp_q16(w - 64'(NM_510), 64'(70 * 1024));
                g = ONE_Q16;
            end else if (w < 64'(NM_645)) begin
                seg = SEG_YELLOW;
                r = ONE_Q16;
                g = ramp_q16(64'(NM_645) - w, 64'(65 * 1024));
            end else begin
                seg = SEG_RED;
                r = ONE_Q16;
            end
            if (w < 64'(NM_420)) begin
                f = 64'(FADE_BASE) + (64'(FADE_SPAN) * (w - 64'(NM_350))) / 64'(70 * 1024);
            end else if (w < 64'(NM_680)) begin
                f = ONE_Q16;
            end else begin
                f = 64'(FADE_BASE) + (64'(FADE_SPAN) * (64'(NM_750) - w)) / 64'(70 * 1024);
            end
        end
        px.blue      = color_byte(b, f);
        px.green     = color_byte(g, f);
        px.red       = color_byte(r, f);
        px.frame_end = frame_end;
    endfunction

    // Mostly depths inside the current band, some right at its edges or just outside them, the rest anywhere.
    function automatic logic [DEPTH_BITS-1:0] pick_depth();
        int lo;
        int hi;
        int lo_c;
        int hi_c;
        int sel;
        lo = int'(band_low) - TOLERANCE;
        hi = int'(band_high) - TOLERANCE;
        lo_c = (lo < 0) ? 0 : lo;
        hi_c = (hi > DEPTH_MAX) ? DEPTH_MAX : hi;
        sel = $urandom_range(0, 9);
        if (hi > lo && lo_c <= hi_c && sel < 8) begin
            if (sel == 0)
                return DEPTH_BITS'($urandom_range(0, 1) ? lo_c : hi_c);
            return DEPTH_BITS'($urandom_range(hi_c, lo_c));
        end
        if (sel == 8 && lo > 0 && $urandom_range(0, 1))
            return DEPTH_BITS'(lo - 1);
        if (sel == 8 && hi >= -1 && hi < DEPTH_MAX)
            return DEPTH_BITS'(hi + 1);
        return DEPTH_BITS'($urandom_range(0, DEPTH_MAX));
    endfunction

    task automatic send_pixel(
        input logic [DEPTH_BITS-1:0] depth,
        input logic                  frame_end,
        input logic                  typed,
        input t_pixel                typed_px
    );
        int     gap;
        t_pixel px;
        logic   in_band;
        t_seg   seg;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 19) == 0)
                burst_left = $urandom_range(10, 30);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_depth_sample <= depth;
        i_frame_end_in <= frame_end;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_pixel(depth, frame_end, band_low, band_high, px, in_band, seg);
        if (in_band) begin
            n_in_band++;
            seg_hits[int'(seg)]++;
        end
        expected_pixels.push_back(typed ? typed_px : px);
        n_sent++;
    endtask

    task automatic wait_results();
        start <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Only called while the pipeline is empty.
    task automatic set_band(input int low, input int high);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DEPTH_LOW;
        i_cfg_data <= DEPTH_BITS'(low);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DEPTH_HIGH;
        i_cfg_data <= DEPTH_BITS'(high);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        band_low  = DEPTH_BITS'(low);
        band_high = DEPTH_BITS'(high);
        n_settings++;
        repeat (2) @(posedge i_clk);
    endtask

    task automatic run_band(input int low, input int high, input int count);
        int k;
        set_band(low, high);
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 199) == 0)
                wait_results();
            send_pixel(pick_depth(), ($urandom_range(0, 7) == 0), 1'b0, '0);
        end
        wait_results();
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_pixel want;
        if (i_rst_n && o_valid) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result b=%0d g=%0d r=%0d end=%0b", $time,
                         o_blue_level, o_green_level, o_red_level, o_frame_end_out);
                n_errors++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("blue_level", want.blue, o_blue_level);
                check_field("green_level", want.green, o_green_level);
                check_field("red_level", want.red, o_red_level);
                check_field("frame_end_out", want.frame_end, o_frame_end_out);
                n_checked++;
            end
        end
    end

    initial begin
        #2000000;
        $display("tb_depth_to_spectrum_color failed");
        $finish;
    end

    initial begin
        int     i;
        int     low_v;
        int     high_v;
        t_pixel typed_px;
        n_sent     = 0;
        n_checked  = 0;
        n_errors   = 0;
        n_in_band  = 0;
        n_settings = 1;
        burst_left = 0;
        for (i = 0; i < N_SEGS; i++)
            seg_hits[i] = 0;
        band_low  = DEPTH_BITS'(RESET_LOW);
        band_high = DEPTH_BITS'(RESET_HIGH);
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_DEPTH_LOW;
        i_cfg_data     <= '0;
        i_depth_sample <= '0;
        i_frame_end_in <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        for (i = 0; i < $size(DIR_ROWS); i++) begin
            typed_px.blue      = DIR_ROWS[i].blue;
            typed_px.green     = DIR_ROWS[i].green;
            typed_px.red       = DIR_ROWS[i].red;
            typed_px.frame_end = DIR_ROWS[i].frame_end;
            send_pixel(DIR_ROWS[i].depth, DIR_ROWS[i].frame_end, DIR_ROWS[i].known, typed_px);
        end
        wait_results();

        // Register extremes, empty and inverted bands, two-point bands and bands cut by zero, then random bands.
        run_band(RESET_LOW, RESET_HIGH, 90);
        run_band(0, DEPTH_MAX, 90);
        run_band(TOLERANCE, DEPTH_MAX, 90);
        run_band(DEPTH_MAX, DEPTH_MAX, 60);
        run_band(0, 0, 60);
        run_band(DEPTH_MAX, 0, 60);
        run_band(100, 101, 60);
        run_band(0, 6, 60);
        run_band(DEPTH_MAX - 1, DEPTH_MAX, 60);
        run_band(1000, 1400, 90);
        for (i = 0; i < 10; i++) begin
            low_v = $urandom_range(0, DEPTH_MAX);
            if ($urandom_range(0, 3) == 0)
                high_v = $urandom_range(0, DEPTH_MAX);
            else
                high_v = low_v + $urandom_range(1, 300);
            if (high_v > DEPTH_MAX)
                high_v = DEPTH_MAX;
            run_band(low_v, high_v, 60);
        end

        wait_results();
        repeat (FLUSH_CYCLES) @(posedge i_clk);
        $display("Sent %0d items over %0d band settings, checked %0d results, %0d in band.",
                 n_sent, n_settings, n_checked, n_in_band);
        $display("In-band items per hue segment, violet to red: %0d %0d %0d %0d %0d %0d.",
                 seg_hits[0], seg_hits[1], seg_hits[2], seg_hits[3], seg_hits[4], seg_hits[5]);
        if (n_errors == 0)
            $display("tb_depth_to_spectrum_color passed");
        else
            $display("tb_depth_to_spectrum_color failed");
        $finish;
    end

endmodule
